// ----- sv/vcps_pkg.sv -----
package vcps_pkg;

    localparam int SLICES_DEF        = 32;
    localparam int ROWS_DEF          = 32;
    localparam int COLUMNS_DEF       = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int IDX_W  = 5;
    localparam int CDF_W  = 17;
    localparam int PICK_W = 16;
    localparam int SPC_W  = 20;
    localparam int OFS_W  = 32;
    localparam int POS_W  = 36;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        REQ_LOAD_SLICE  = 2'd0,
        REQ_LOAD_ROW    = 2'd1,
        REQ_LOAD_COLUMN = 2'd2,
        REQ_SAMPLE      = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z  = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  slice_index;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  column_index;
        logic [CDF_W-1:0]  cdf_value;
        logic [PICK_W-1:0] pick_z;
        logic [PICK_W-1:0] pick_y;
        logic [PICK_W-1:0] pick_x;
        logic [PICK_W-1:0] jitter_x;
        logic [PICK_W-1:0] jitter_y;
        logic [PICK_W-1:0] jitter_z;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        voxel_col;
        logic [IDX_W-1:0]        voxel_row;
        logic [IDX_W-1:0]        voxel_slice;
        logic                    overrun;
    } t_out;

    // sample work handed from front to back
    typedef struct packed {
        logic [PICK_W-1:0] pick_z;
        logic [PICK_W-1:0] pick_y;
        logic [PICK_W-1:0] pick_x;
        logic [PICK_W-1:0] jitter_x;
        logic [PICK_W-1:0] jitter_y;
        logic [PICK_W-1:0] jitter_z;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- sv/vcps_job_fifo.sv -----
module vcps_job_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vcps_pkg::t_job  i_data,
    input  logic            i_pop,
    output vcps_pkg::t_job  o_data,
    output vcps_pkg::t_qstat o_stat
);
    // two-entry queue
    vcps_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule

// ----- sv/vcps_front.sv -----
module vcps_front (
    input  logic             i_push,
    input  vcps_pkg::t_in    i_in,
    output logic             o_full,
    input  vcps_pkg::t_qstat i_qstat,
    output logic             o_job_push,
    output vcps_pkg::t_job   o_job,
    output logic             o_ld_slice,
    output logic             o_ld_row,
    output logic             o_ld_col,
    output logic [vcps_pkg::IDX_W-1:0] o_si,
    output logic [vcps_pkg::IDX_W-1:0] o_ri,
    output logic [vcps_pkg::IDX_W-1:0] o_ci,
    output logic [vcps_pkg::CDF_W-1:0] o_val
);
    // Loads are applied at once to the tables (in back); they never overtake a sample,
    // since the queue must be empty and back idle before a load is taken (i_qstat.empty
    // folds in back-busy by the top level).
    logic acc, is_smp;
    assign is_smp = (i_in.req_type == vcps_pkg::REQ_SAMPLE);
    assign o_full = is_smp ? i_qstat.full : !i_qstat.empty;
    assign acc    = i_push && !o_full;

    assign o_job_push = acc && is_smp;
    assign o_job = '{pick_z: i_in.pick_z, pick_y: i_in.pick_y, pick_x: i_in.pick_x,
                     jitter_x: i_in.jitter_x, jitter_y: i_in.jitter_y,
                     jitter_z: i_in.jitter_z};
    assign o_ld_slice = acc && (i_in.req_type == vcps_pkg::REQ_LOAD_SLICE);
    assign o_ld_row   = acc && (i_in.req_type == vcps_pkg::REQ_LOAD_ROW);
    assign o_ld_col   = acc && (i_in.req_type == vcps_pkg::REQ_LOAD_COLUMN);
    assign o_si  = i_in.slice_index;
    assign o_ri  = i_in.row_index;
    assign o_ci  = i_in.column_index;
    assign o_val = i_in.cdf_value;
endmodule

// ----- sv/vcps_back.sv -----
module vcps_back #(
    parameter int SLICES        = vcps_pkg::SLICES_DEF,
    parameter int ROWS          = vcps_pkg::ROWS_DEF,
    parameter int COLUMNS       = vcps_pkg::COLUMNS_DEF,
    parameter int FRACTION_BITS = vcps_pkg::FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ld_slice,
    input  logic            i_ld_row,
    input  logic            i_ld_col,
    input  logic [vcps_pkg::IDX_W-1:0] i_si,
    input  logic [vcps_pkg::IDX_W-1:0] i_ri,
    input  logic [vcps_pkg::IDX_W-1:0] i_ci,
    input  logic [vcps_pkg::CDF_W-1:0] i_val,
    input  logic            i_job_valid,
    input  vcps_pkg::t_job  i_job,
    output logic            o_job_pop,
    output logic            o_busy,
    input  logic [vcps_pkg::SPC_W-1:0] i_spc [3],
    input  logic [vcps_pkg::OFS_W-1:0] i_ofs [3],
    output logic            o_res_valid,
    output vcps_pkg::t_out  o_res,
    input  logic            i_res_pop
);
    localparam int SW = (SLICES  > 1) ? $clog2(SLICES)  : 1;
    localparam int RW = (ROWS    > 1) ? $clog2(ROWS)    : 1;
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int NW = (SW > RW) ? ((SW > CW) ? SW : CW) : ((RW > CW) ? RW : CW);
    localparam int RAW = (SLICES*ROWS > 1) ? $clog2(SLICES*ROWS) : 1;
    localparam int CAW = (SLICES*ROWS*COLUMNS > 1) ? $clog2(SLICES*ROWS*COLUMNS) : 1;
    localparam int PW = vcps_pkg::POS_W;
    localparam int MW = vcps_pkg::SPC_W + vcps_pkg::PICK_W;

    logic [vcps_pkg::CDF_W-1:0] r_smem [SLICES];
    logic [vcps_pkg::CDF_W-1:0] r_rmem [SLICES*ROWS];
    logic [vcps_pkg::CDF_W-1:0] r_cmem [SLICES*ROWS*COLUMNS];

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_CMP = 7'b0000100,
        S_MUL  = 7'b0001000, S_ADD = 7'b0010000, S_OUT = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state r_st;
    logic [1:0]    r_lvl;     // 0 slice, 1 row, 2 column
    logic [NW:0]   r_n;
    logic [SW-1:0] r_i;
    logic [RW-1:0] r_j;
    logic [CW-1:0] r_k;
    logic          r_flag;
    logic [1:0]    r_ax;
    vcps_pkg::t_job r_job;
    logic [vcps_pkg::CDF_W-1:0] r_rd;
    logic [MW-1:0] r_prod;
    logic [vcps_pkg::SPC_W+NW-1:0] r_base;
    logic [PW-1:0] r_pos [3];
    logic          r_valid;
    vcps_pkg::t_out r_res;

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_ld_slice && 32'(i_si) < SLICES) r_smem[SW'(i_si)] <= i_val;
        if (i_ld_row && 32'(i_si) < SLICES && 32'(i_ri) < ROWS)
            r_rmem[RAW'(32'(i_si) * ROWS + 32'(i_ri))] <= i_val;
        if (i_ld_col && 32'(i_si) < SLICES && 32'(i_ri) < ROWS && 32'(i_ci) < COLUMNS)
            r_cmem[CAW'((32'(i_si) * ROWS + 32'(i_ri)) * COLUMNS + 32'(i_ci))] <= i_val;
    end

    // linear search, one registered read per step
    logic [31:0] cnt, addr;
    logic [vcps_pkg::PICK_W-1:0] pick;
    always_comb begin
        case (r_lvl)
            2'd0: begin cnt = 32'(SLICES);  pick = r_job.pick_z; end
            2'd1: begin cnt = 32'(ROWS);    pick = r_job.pick_y; end
            default: begin cnt = 32'(COLUMNS); pick = r_job.pick_x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_lvl)
            2'd0: r_rd <= r_smem[r_n[SW-1:0]];
            2'd1: r_rd <= r_rmem[RAW'(32'(r_i) * ROWS + 32'(r_n))];
            default: r_rd <= r_cmem[CAW'((32'(r_i) * ROWS + 32'(r_j)) * COLUMNS + 32'(r_n))];
        endcase
    end
    assign addr = 32'(r_n);

    logic [vcps_pkg::SPC_W-1:0] spc;
    logic [vcps_pkg::PICK_W-1:0] jit;
    logic [NW-1:0] idx;
    always_comb begin
        case (r_ax)
            2'd0: begin spc = i_spc[0]; jit = r_job.jitter_x; idx = NW'(r_k); end
            2'd1: begin spc = i_spc[1]; jit = r_job.jitter_y; idx = NW'(r_j); end
            default: begin spc = i_spc[2]; jit = r_job.jitter_z; idx = NW'(r_i); end
        endcase
    end

    logic found, last;
    assign found = ({1'b0, pick} <= r_rd);
    assign last  = (addr + 32'd1 >= cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_res_pop && r_st != S_WAIT) r_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job; r_lvl <= 2'd0; r_n <= '0; r_flag <= 1'b0;
                    r_st <= S_RD;
                end
                S_RD: r_st <= S_CMP;
                S_CMP: begin
                    if (found || last) begin
                        if (!found) r_flag <= 1'b1;
                        case (r_lvl)
                            2'd0: r_i <= r_n[SW-1:0];
                            2'd1: r_j <= r_n[RW-1:0];
                            default: r_k <= r_n[CW-1:0];
                        endcase
                        r_n <= '0;
                        if (r_lvl == 2'd2) begin r_ax <= 2'd0; r_st <= S_MUL; end
                        else begin r_lvl <= r_lvl + 2'd1; r_st <= S_RD; end
                    end else begin
                        r_n <= r_n + 1'b1; r_st <= S_RD;
                    end
                end
                S_MUL: begin
                    r_prod <= MW'(spc) * MW'(jit);
                    r_base <= (vcps_pkg::SPC_W+NW)'(spc) * (vcps_pkg::SPC_W+NW)'(idx);
                    r_st <= S_ADD;
                end
                S_ADD: begin
                    r_pos[r_ax] <= PW'(signed'(i_ofs[r_ax])) + PW'(r_base)
                                 + PW'(r_prod >> FRACTION_BITS);
                    if (r_ax == 2'd2) r_st <= S_OUT;
                    else begin r_ax <= r_ax + 2'd1; r_st <= S_MUL; end
                end
                S_OUT: r_st <= S_WAIT;
                S_WAIT: if (!r_valid || i_res_pop) begin
                    r_valid <= 1'b1;
                    r_res <= '{pos_x: r_pos[0], pos_y: r_pos[1], pos_z: r_pos[2],
                               voxel_col: vcps_pkg::IDX_W'(r_k),
                               voxel_row: vcps_pkg::IDX_W'(r_j),
                               voxel_slice: vcps_pkg::IDX_W'(r_i), overrun: r_flag};
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_job_pop   = (r_st == S_IDLE) && i_job_valid;
    assign o_busy      = (r_st != S_IDLE);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;
endmodule

// ----- sv/voxel_cdf_position_sampler_core.sv -----
// Channel | Direction | Handshake        | Payload
// input   | in        | push / full      | i_in (t_in)
// result  | out       | pop / empty      | o_out (t_out)
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Loads write the tables directly. A queued sample walks three linear searches,
// each entry visited costing a registered table read then a compare, then three
// multiply/add passes (multiply, then add), then S_OUT and S_WAIT before the
// result is placed in the output register.
// Reset is synchronous, active low; tables are not cleared.
// A load waits until earlier samples have left the back end; a finished
// result waits in the output register while the next sample may start.
module voxel_cdf_position_sampler_core #(
    parameter int SLICES        = vcps_pkg::SLICES_DEF,
    parameter int ROWS          = vcps_pkg::ROWS_DEF,
    parameter int COLUMNS       = vcps_pkg::COLUMNS_DEF,
    parameter int FRACTION_BITS = vcps_pkg::FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  vcps_pkg::t_in   i_in,
    output logic            empty,
    input  logic            pop,
    output vcps_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [vcps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    logic [vcps_pkg::SPC_W-1:0] r_spc [3];
    logic [vcps_pkg::OFS_W-1:0] r_ofs [3];

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc[0] <= 20'd1024; r_spc[1] <= 20'd1024; r_spc[2] <= 20'd1024;
            r_ofs[0] <= '0; r_ofs[1] <= '0; r_ofs[2] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vcps_pkg::CFG_SPACING_X: r_spc[0] <= i_cfg_data[19:0];
                vcps_pkg::CFG_SPACING_Y: r_spc[1] <= i_cfg_data[19:0];
                vcps_pkg::CFG_SPACING_Z: r_spc[2] <= i_cfg_data[19:0];
                vcps_pkg::CFG_OFFSET_X:  r_ofs[0] <= i_cfg_data;
                vcps_pkg::CFG_OFFSET_Y:  r_ofs[1] <= i_cfg_data;
                vcps_pkg::CFG_OFFSET_Z:  r_ofs[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vcps_pkg::t_qstat qs, qs_front;
    vcps_pkg::t_job   job_in, job_out;
    logic job_push, job_pop, busy, res_valid;
    logic ld_s, ld_r, ld_c;
    logic [vcps_pkg::IDX_W-1:0] si, ri, ci;
    logic [vcps_pkg::CDF_W-1:0] val;

    // loads need the back end quiet
    assign qs_front.full  = qs.full;
    assign qs_front.empty = qs.empty && !busy;

    vcps_front u_front (
        .i_push(push), .i_in, .o_full(full), .i_qstat(qs_front),
        .o_job_push(job_push), .o_job(job_in), .o_ld_slice(ld_s), .o_ld_row(ld_r),
        .o_ld_col(ld_c), .o_si(si), .o_ri(ri), .o_ci(ci), .o_val(val)
    );

    vcps_job_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(job_push), .i_data(job_in), .i_pop(job_pop),
        .o_data(job_out), .o_stat(qs)
    );

    vcps_back #(.SLICES(SLICES), .ROWS(ROWS), .COLUMNS(COLUMNS),
                .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_ld_slice(ld_s), .i_ld_row(ld_r), .i_ld_col(ld_c),
        .i_si(si), .i_ri(ri), .i_ci(ci), .i_val(val), .i_job_valid(!qs.empty),
        .i_job(job_out), .o_job_pop(job_pop), .o_busy(busy), .i_spc(r_spc),
        .i_ofs(r_ofs), .o_res_valid(res_valid), .o_res(o_out),
        .i_res_pop(pop && !empty)
    );

    assign empty = !res_valid;

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qs.empty |-> !job_pop) else $error("job popped from empty queue");
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_s || ld_r || ld_c) |-> (qs.empty && !busy)) else $error("load during sample");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
`endif
endmodule

// ----- bench/voxel_cdf_position_sampler_core_tb.sv -----
module voxel_cdf_position_sampler_core_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 300;
    localparam int NSLICE = vcps_pkg::SLICES_DEF;
    localparam int NROW   = vcps_pkg::ROWS_DEF;
    localparam int NCOL   = vcps_pkg::COLUMNS_DEF;
    localparam int IW     = vcps_pkg::IDX_W;
    localparam int VW     = vcps_pkg::CDF_W;
    localparam int KW     = vcps_pkg::PICK_W;
    localparam int PSW    = vcps_pkg::POS_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    vcps_pkg::t_in        i_in = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    vcps_pkg::t_out       o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [vcps_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    voxel_cdf_position_sampler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the three cdf tables plus "written" flags, so that the
    // stimulus never sends a sample whose search would touch an unset entry
    logic [VW-1:0] slice_tab [NSLICE];
    logic [VW-1:0] row_tab   [NSLICE*NROW];
    logic [VW-1:0] col_tab   [NSLICE*NROW*NCOL];
    bit            slice_set [NSLICE];
    bit            row_set   [NSLICE*NROW];
    bit            col_set   [NSLICE*NROW*NCOL];

    logic [vcps_pkg::SPC_W-1:0] spacing [3];    // x, y, z
    logic [vcps_pkg::OFS_W-1:0] offset  [3];

    vcps_pkg::t_out positions_q[$];   // expected samples, oldest first
    int   mismatches = 0;
    int   cyc = 0;
    bit   steady = 1'b0;    // no random idling on either side
    int   hold_req = 0;     // receiver back-pressure request: 0 none yet, -1 asked, 1 taken

    typedef struct {
        vcps_pkg::t_in  item;
        bit             typed;
        vcps_pkg::t_out want;
    } t_dir_row;

    function automatic vcps_pkg::t_in make_in(vcps_pkg::t_req rt, int si, int ri, int ci,
            int val, int pz, int py, int px, int jx, int jy, int jz);
        vcps_pkg::t_in r;
        r.req_type = rt;
        r.slice_index = IW'(si);
        r.row_index = IW'(ri);
        r.column_index = IW'(ci);
        r.cdf_value = VW'(val);
        r.pick_z = KW'(pz);
        r.pick_y = KW'(py);
        r.pick_x = KW'(px);
        r.jitter_x = KW'(jx);
        r.jitter_y = KW'(jy);
        r.jitter_z = KW'(jz);
        return r;
    endfunction

    function automatic logic [PSW-1:0] place_axis(logic [vcps_pkg::SPC_W-1:0] spc,
            logic [vcps_pkg::OFS_W-1:0] ofs, int idx, logic [KW-1:0] jit);
        longint p;
        p = longint'($signed(ofs)) + longint'(spc) * idx
            + ((longint'(spc) * longint'(jit)) >>> vcps_pkg::FRACTION_BITS_DEF);
        return p[PSW-1:0];
    endfunction

    // first index whose cdf is not below pick; saturates and flags overrun
    function automatic vcps_pkg::t_out predict_sample(vcps_pkg::t_in s);
        vcps_pkg::t_out r;
        int i, j, k, base;
        bit ov;
        ov = 1'b0;
        i = -1;
        for (int n = 0; n < NSLICE && i < 0; n++)
            if ({1'b0, s.pick_z} <= slice_tab[n]) i = n;
        if (i < 0) begin
            i = NSLICE - 1;
            ov = 1'b1;
        end
        j = -1;
        base = i * NROW;
        for (int n = 0; n < NROW && j < 0; n++)
            if ({1'b0, s.pick_y} <= row_tab[base + n]) j = n;
        if (j < 0) begin
            j = NROW - 1;
            ov = 1'b1;
        end
        k = -1;
        base = (i * NROW + j) * NCOL;
        for (int n = 0; n < NCOL && k < 0; n++)
            if ({1'b0, s.pick_x} <= col_tab[base + n]) k = n;
        if (k < 0) begin
            k = NCOL - 1;
            ov = 1'b1;
        end
        r.pos_x = place_axis(spacing[0], offset[0], k, s.jitter_x);
        r.pos_y = place_axis(spacing[1], offset[1], j, s.jitter_y);
        r.pos_z = place_axis(spacing[2], offset[2], i, s.jitter_z);
        r.voxel_col = IW'(k);
        r.voxel_row = IW'(j);
        r.voxel_slice = IW'(i);
        r.overrun = ov;
        return r;
    endfunction

    function automatic void store_entry(vcps_pkg::t_in s);
        int ri, ci;
        ri = s.slice_index * NROW + s.row_index;
        ci = ri * NCOL + s.column_index;
        case (vcps_pkg::t_req'(s.req_type))
            vcps_pkg::REQ_LOAD_SLICE: begin
                slice_tab[s.slice_index] = s.cdf_value;
                slice_set[s.slice_index] = 1'b1;
            end
            vcps_pkg::REQ_LOAD_ROW: begin
                row_tab[ri] = s.cdf_value;
                row_set[ri] = 1'b1;
            end
            vcps_pkg::REQ_LOAD_COLUMN: begin
                col_tab[ci] = s.cdf_value;
                col_set[ci] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // cdf fill values: mix of extremes, small values and uniform; low_bias gives small values only
    function automatic int cdf_value_draw(bit low_bias);
        int r;
        r = $urandom_range(0, 99);
        if (low_bias) return $urandom_range(0, 3000);
        if (r < 15) return 0;
        if (r < 30) return 65536;
        if (r < 55) return $urandom_range(0, 3000);
        return $urandom_range(0, 65536);
    endfunction

    // walk the search the sample would do; report the first unset entry
    // on that path as a load that fills it
    function automatic bit find_hole(vcps_pkg::t_in s, output vcps_pkg::t_in ld);
        int i, j, base;
        ld = make_in(vcps_pkg::REQ_LOAD_SLICE, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 31), 0, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        i = NSLICE - 1;
        for (int n = 0; n < NSLICE; n++) begin
            if (!slice_set[n]) begin
                ld.slice_index = IW'(n);
                ld.cdf_value = VW'(cdf_value_draw(1'b0));
                return 1'b1;
            end
            if ({1'b0, s.pick_z} <= slice_tab[n]) begin
                i = n;
                break;
            end
        end
        j = NROW - 1;
        base = i * NROW;
        for (int n = 0; n < NROW; n++) begin
            if (!row_set[base + n]) begin
                ld.req_type = vcps_pkg::REQ_LOAD_ROW;
                ld.slice_index = IW'(i);
                ld.row_index = IW'(n);
                ld.cdf_value = VW'(cdf_value_draw(i == NSLICE - 1));
                return 1'b1;
            end
            if ({1'b0, s.pick_y} <= row_tab[base + n]) begin
                j = n;
                break;
            end
        end
        base = (i * NROW + j) * NCOL;
        for (int n = 0; n < NCOL; n++) begin
            if (!col_set[base + n]) begin
                ld.req_type = vcps_pkg::REQ_LOAD_COLUMN;
                ld.slice_index = IW'(i);
                ld.row_index = IW'(j);
                ld.column_index = IW'(n);
                ld.cdf_value = VW'(cdf_value_draw(j == NROW - 1));
                return 1'b1;
            end
            if ({1'b0, s.pick_x} <= col_tab[base + n]) break;
        end
        return 1'b0;
    endfunction

    function automatic int pick_draw();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        return $urandom_range(0, 65535);
    endfunction

    // one input beat; typed expectation used when given, else predictor
    task automatic send_beat(vcps_pkg::t_in s, bit typed, vcps_pkg::t_out want);
        while (!steady && $urandom_range(0, 99) < 27) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_in = s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (s.req_type == vcps_pkg::REQ_SAMPLE)
            positions_q.push_back(typed ? want : predict_sample(s));
        else
            store_entry(s);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic send_random(int count);
        vcps_pkg::t_in s, ld;
        vcps_pkg::t_out none;
        int sent;
        none = '0;
        sent = 0;
        while (sent < count) begin
            s = make_in(vcps_pkg::REQ_SAMPLE, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 131071),
                        pick_draw(), pick_draw(), pick_draw(),
                        pick_draw(), pick_draw(), pick_draw());
            if ($urandom_range(0, 99) < 15) begin
                // stray load anywhere, value 0 to 65536
                s.req_type = vcps_pkg::t_req'($urandom_range(0, 2));
                s.cdf_value = VW'(cdf_value_draw(1'b0));
            end else begin
                while (find_hole(s, ld)) begin
                    send_beat(ld, 1'b0, none);
                    sent++;
                end
            end
            send_beat(s, 1'b0, none);
            sent++;
            if (sent >= 20 && hold_req == 0) hold_req = -1;
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (positions_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [vcps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            vcps_pkg::CFG_SPACING_X: spacing[0] = data[vcps_pkg::SPC_W-1:0];
            vcps_pkg::CFG_SPACING_Y: spacing[1] = data[vcps_pkg::SPC_W-1:0];
            vcps_pkg::CFG_SPACING_Z: spacing[2] = data[vcps_pkg::SPC_W-1:0];
            vcps_pkg::CFG_OFFSET_X:  offset[0] = data;
            vcps_pkg::CFG_OFFSET_Y:  offset[1] = data;
            vcps_pkg::CFG_OFFSET_Z:  offset[2] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic cfg_all(logic [31:0] spc, logic [31:0] ofs);
        cfg_write(vcps_pkg::CFG_SPACING_X, spc);
        cfg_write(vcps_pkg::CFG_SPACING_Y, spc);
        cfg_write(vcps_pkg::CFG_SPACING_Z, spc);
        cfg_write(vcps_pkg::CFG_OFFSET_X, ofs);
        cfg_write(vcps_pkg::CFG_OFFSET_Y, ofs);
        cfg_write(vcps_pkg::CFG_OFFSET_Z, ofs);
    endtask

    // receiver: random pop, or a long hold-off when the sender asks for one
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req < 0) begin
                hold_req = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop = 1'b0;
            end else begin
                pop = steady || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    // result checker: every popped beat against the oldest expectation
    always @(posedge i_clk) begin
        vcps_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (positions_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", o_out);
            end else begin
                want = positions_q.pop_front();
                if (o_out.pos_x !== want.pos_x || o_out.pos_y !== want.pos_y ||
                    o_out.pos_z !== want.pos_z || o_out.voxel_col !== want.voxel_col ||
                    o_out.voxel_row !== want.voxel_row ||
                    o_out.voxel_slice !== want.voxel_slice ||
                    o_out.overrun !== want.overrun) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, o_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("voxel_cdf_position_sampler_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_dir_row       dir_tab[$];
        t_dir_row       row;
        vcps_pkg::t_out w;

        for (int n = 0; n < 3; n++) begin
            spacing[n] = 20'd1024;
            offset[n] = '0;
        end

        // directed: zero-valued first entries, index and value extremes
        row.typed = 1'b0;
        row.want = '0;
        row.item = make_in(vcps_pkg::REQ_LOAD_SLICE, 0, 31, 31, 0, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        row.item = make_in(vcps_pkg::REQ_LOAD_ROW, 0, 0, 31, 0, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        row.item = make_in(vcps_pkg::REQ_LOAD_COLUMN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        // all picks zero, zero jitter: origin of voxel 0
        row.item = make_in(vcps_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        row.typed = 1'b1;
        dir_tab.push_back(row);
        // full jitter: 1024*65535 >> 16 = 1023 on every axis
        row.item = make_in(vcps_pkg::REQ_SAMPLE, 31, 31, 31, 65536, 0, 0, 0,
                           65535, 65535, 65535);
        w = '0;
        w.pos_x = PSW'(1023);
        w.pos_y = PSW'(1023);
        w.pos_z = PSW'(1023);
        row.want = w;
        dir_tab.push_back(row);
        row.typed = 1'b0;
        row.item = make_in(vcps_pkg::REQ_LOAD_SLICE, 31, 0, 0, 65536, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        row.item = make_in(vcps_pkg::REQ_LOAD_ROW, 31, 31, 0, 65536, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        row.item = make_in(vcps_pkg::REQ_LOAD_COLUMN, 31, 31, 31, 65536, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        // value above one fraction is stored as is
        row.item = make_in(vcps_pkg::REQ_LOAD_COLUMN, 0, 0, 1, 131071, 0, 0, 0, 0, 0, 0);
        dir_tab.push_back(row);
        row.item = make_in(vcps_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 32768, 1, 65535);
        dir_tab.push_back(row);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[n])
            send_beat(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].want);

        // largest spacing, most negative offset; receiver hold-off here
        wait_idle();
        cfg_all(32'hFFFF_FFFF, 32'h8000_0000);
        send_random(120);

        // zero spacing, most positive offset, no idling anywhere
        wait_idle();
        cfg_all(32'h0, 32'h7FFF_FFFF);
        steady = 1'b1;
        send_random(100);
        steady = 1'b0;

        // random setting; slice cdf rewritten small so high picks overrun
        wait_idle();
        cfg_all($urandom, $urandom);
        cfg_write(vcps_pkg::CFG_SPACING_Y, $urandom);
        cfg_write(vcps_pkg::CFG_OFFSET_Z, $urandom);
        for (int n = 0; n < NSLICE; n++)
            send_beat(make_in(vcps_pkg::REQ_LOAD_SLICE, n, 0, 0, $urandom_range(0, 30000),
                              0, 0, 0, 0, 0, 0), 1'b0, '0);
        send_random(130);

        wait_idle();
        cfg_all(32'h1, $urandom);
        send_random(130);

        wait_idle();
        if (mismatches == 0)
            $display("voxel_cdf_position_sampler_core_tb: done, clean");
        else
            $display("voxel_cdf_position_sampler_core_tb: done, errors");
        $finish;
    end

endmodule
